/* design/pte_pkg.sv */
package pte_pkg;

    localparam int LINE_LIMIT    = 70;
    localparam int MAX_DIMENSION = 4095;
    localparam int DIM_W         = 12;
    localparam int LL_W          = $clog2(LINE_LIMIT + 2);
    localparam int CFG_IDX_W     = 2;
    localparam int BCD_DIGITS    = 4;
    localparam int DEC_CNT_W     = $clog2(BCD_DIGITS + 1);
    localparam int STEP_W        = $clog2(DIM_W + 1);
    localparam int NUM_LANES     = 3;
    localparam int COMP_DIGITS   = 3;
    localparam int HDR_SLOTS     = 17;
    localparam int LANE_SLOTS    = COMP_DIGITS + 1;
    localparam int NUM_SLOTS     = HDR_SLOTS + NUM_LANES * LANE_SLOTS + 1;

    // slot layout of one burst of characters
    localparam int SLOT_WIDTH    = 3;
    localparam int SLOT_HEIGHT   = 8;
    localparam int SLOT_LANE     = HDR_SLOTS;
    localparam int SLOT_ROW_END  = NUM_SLOTS - 1;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_P     = 8'h50;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_of_item;
        logic       frame_done;
    } text_t;

    typedef struct packed {
        logic [1:0]                  size;
        logic [COMP_DIGITS-1:0][7:0] digit;
    } lane_t;

    typedef struct packed {
        logic [BCD_DIGITS-1:0][3:0] digit;
        logic [DEC_CNT_W-1:0]       count;
    } dec_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]      mask;
        logic [NUM_SLOTS-1:0][7:0] chars;
        logic                      frame_end;
    } burst_t;

endpackage

/* design/pte_lane.sv */
module pte_lane
    import pte_pkg::*;
(
    input  logic [7:0] value,
    output lane_t      digits
);

    logic [1:0]  hund;
    logic [7:0]  rem;
    logic [15:0] prod;
    logic [3:0]  tens;
    logic [7:0]  tens_x10;
    logic [7:0]  ones;

    always_comb begin
        hund = (value >= 8'd200) ? 2'd2 : ((value >= 8'd100) ? 2'd1 : 2'd0);
        rem  = value - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));
        // rem is below 100, so times 205 over 2048 gives rem / 10 exactly
        prod     = {9'd0, rem[6:0]} * 16'd205;
        tens     = prod[14:11];
        tens_x10 = {4'd0, tens} * 8'd10;
        ones     = rem - tens_x10;

        digits.size     = (value >= 8'd100) ? 2'd3 : ((value >= 8'd10) ? 2'd2 : 2'd1);
        digits.digit[2] = CH_ZERO + {6'd0, hund};
        digits.digit[1] = CH_ZERO + {4'd0, tens};
        digits.digit[0] = CH_ZERO + ones;
    end

endmodule

/* design/pte_dabble.sv */
module pte_dabble
    import pte_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             start_height,
    input  logic [DIM_W-1:0] value,
    output logic             busy,
    output dec_t             width_dec,
    output dec_t             height_dec
);

    logic                    busy_reg, busy_next;
    logic                    sel_reg, sel_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [DIM_W-1:0]        bin_reg, bin_next;
    logic [4*BCD_DIGITS-1:0] bcd_reg, bcd_next;
    dec_t                    width_reg, width_next;
    dec_t                    height_reg, height_next;

    logic [4*BCD_DIGITS-1:0] adj;
    logic [4*BCD_DIGITS-1:0] shifted;
    dec_t                    result;

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                        : bcd_reg[4*i +: 4];
        end
        shifted = {adj[4*BCD_DIGITS-2:0], bin_reg[DIM_W-1]};

        result.digit = shifted;
        result.count = DEC_CNT_W'(1);
        for (int i = 1; i < BCD_DIGITS; i++) begin
            if (shifted[4*i +: 4] != 4'd0) begin
                result.count = DEC_CNT_W'(i + 1);
            end
        end

        busy_next   = busy_reg;
        sel_next    = sel_reg;
        step_next   = step_reg;
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        width_next  = width_reg;
        height_next = height_reg;

        if (busy_reg) begin
            bcd_next  = shifted;
            bin_next  = {bin_reg[DIM_W-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIM_W - 1)) begin
                busy_next = 1'b0;
                if (sel_reg) begin
                    height_next = result;
                end else begin
                    width_next = result;
                end
            end
        end else if (start) begin
            busy_next = 1'b1;
            sel_next  = start_height;
            step_next = '0;
            bin_next  = value;
            bcd_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            width_reg  <= '{digit: (4*BCD_DIGITS)'(1), count: DEC_CNT_W'(1)};
            height_reg <= '{digit: (4*BCD_DIGITS)'(1), count: DEC_CNT_W'(1)};
        end else begin
            busy_reg   <= busy_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
        sel_reg  <= sel_next;
        step_reg <= step_next;
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
    end

    assign busy       = busy_reg;
    assign width_dec  = width_reg;
    assign height_dec = height_reg;

endmodule

/* design/pte_serializer.sv */
module pte_serializer
    import pte_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   load,
    input  burst_t burst,
    output logic   load_ready,
    output logic   m_valid,
    input  logic   m_ready,
    output text_t  m_data
);

    logic [NUM_SLOTS-1:0]      mask_reg, mask_next;
    logic [NUM_SLOTS-1:0][7:0] chars_reg, chars_next;
    logic                      frame_end_reg, frame_end_next;
    logic                      m_valid_reg, m_valid_next;
    text_t                     m_data_reg, m_data_next;

    logic [NUM_SLOTS-1:0] first;
    logic [7:0]           pick;
    logic                 out_free;
    logic                 emit;
    logic                 last;

    always_comb begin
        // lowest pending slot goes out next
        first = mask_reg & (~mask_reg + NUM_SLOTS'(1));
        pick  = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            pick = pick | (chars_reg[i] & {8{first[i]}});
        end
        last     = (mask_reg & ~first) == '0;
        out_free = !m_valid_reg || m_ready;
        emit     = (mask_reg != '0) && out_free;

        load_ready = (mask_reg == '0) || (emit && last);

        mask_next      = mask_reg;
        chars_next     = chars_reg;
        frame_end_next = frame_end_reg;
        if (load) begin
            mask_next      = burst.mask;
            chars_next     = burst.chars;
            frame_end_next = burst.frame_end;
        end else if (emit) begin
            mask_next = mask_reg & ~first;
        end

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next             = 1'b1;
            m_data_next.text_char    = pick;
            m_data_next.last_of_item = last;
            m_data_next.frame_done   = last && frame_end_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
        chars_reg     <= chars_next;
        frame_end_reg <= frame_end_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* design/ppm_text_encoder.sv */
// Plain PPM (P3) text writer: one pixel word in, its ASCII text out one character
// per word, the header "P3\n<w> <h>\n255\n" ahead of each frame's first pixel. The
// output register sends one character per cycle while m_ready stays high; three
// lanes turn the components into digits as the pixel is taken, a merge step
// places separators and line breaks, and the next pixel is taken while the
// current one drains. A write to the width or height register runs the decimal
// conversion for the header, during which neither port takes a word.
module ppm_text_encoder
    import pte_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pixel_t               s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output text_t                m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [LL_W-1:0]  ll_reg, ll_next;
    logic             hdr_sent_reg, hdr_sent_next;
    logic             st_valid_reg, st_valid_next;
    lane_t [NUM_LANES-1:0] st_lane_reg, st_lane_next;

    lane_t [NUM_LANES-1:0] lane_out;
    logic [NUM_LANES-1:0][7:0] comp;

    logic             cfg_fire;
    logic [DIM_W-1:0] cfg_value;
    logic             conv_start;
    logic             conv_busy;
    dec_t             width_dec;
    dec_t             height_dec;

    logic             ser_ready;
    logic             load;
    burst_t           burst;

    logic [LL_W:0]    ll;
    logic [LL_W:0]    sum;
    logic [LL_W:0]    size_ext;
    logic [DIM_W:0]   col_inc;
    logic [DIM_W:0]   row_inc;
    logic             row_end;
    logic             frame_end;

    assign comp[0] = s_data.red;
    assign comp[1] = s_data.green;
    assign comp[2] = s_data.blue;

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        pte_lane u_lane (
            .value  (comp[k]),
            .digits (lane_out[k])
        );
    end

    assign cfg_ready  = !conv_busy;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign cfg_value  = (cfg_data > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : cfg_data;
    assign conv_start = cfg_fire && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

    pte_dabble u_dabble (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (conv_start),
        .start_height (cfg_index == REG_HEIGHT),
        .value        (cfg_value),
        .busy         (conv_busy),
        .width_dec    (width_dec),
        .height_dec   (height_dec)
    );

    assign load    = st_valid_reg && !conv_busy && ser_ready;
    assign s_ready = !conv_busy && (!st_valid_reg || load);

    // merge: header, separators, line breaks and row end for the staged pixel
    always_comb begin
        burst    = '0;
        ll       = hdr_sent_reg ? {1'b0, ll_reg} : '0;
        sum      = '0;
        size_ext = '0;

        if (!hdr_sent_reg) begin
            burst.mask[HDR_SLOTS-1:0] = '1;
            burst.chars[0]  = CH_P;
            burst.chars[1]  = CH_THREE;
            burst.chars[2]  = CH_NL;
            burst.chars[SLOT_WIDTH + BCD_DIGITS]  = CH_SPACE;
            burst.chars[SLOT_HEIGHT + BCD_DIGITS] = CH_NL;
            burst.chars[SLOT_HEIGHT + BCD_DIGITS + 1] = CH_TWO;
            burst.chars[SLOT_HEIGHT + BCD_DIGITS + 2] = CH_FIVE;
            burst.chars[SLOT_HEIGHT + BCD_DIGITS + 3] = CH_FIVE;
            burst.chars[SLOT_HEIGHT + BCD_DIGITS + 4] = CH_NL;
            for (int j = 0; j < BCD_DIGITS; j++) begin
                // leading zeros of the dimensions are dropped
                burst.mask[SLOT_WIDTH + j]   = width_dec.count >= DEC_CNT_W'(BCD_DIGITS - j);
                burst.mask[SLOT_HEIGHT + j]  = height_dec.count >= DEC_CNT_W'(BCD_DIGITS - j);
                burst.chars[SLOT_WIDTH + j]  =
                    CH_ZERO + {4'd0, width_dec.digit[BCD_DIGITS-1-j]};
                burst.chars[SLOT_HEIGHT + j] =
                    CH_ZERO + {4'd0, height_dec.digit[BCD_DIGITS-1-j]};
            end
        end

        for (int k = 0; k < NUM_LANES; k++) begin
            size_ext = {{(LL_W-1){1'b0}}, st_lane_reg[k].size};
            if (ll != '0) begin
                sum = ll + size_ext;
                burst.mask[SLOT_LANE + k*LANE_SLOTS] = 1'b1;
                if (sum > (LL_W+1)'(LINE_LIMIT)) begin
                    burst.chars[SLOT_LANE + k*LANE_SLOTS] = CH_NL;
                    ll = '0;
                end else begin
                    burst.chars[SLOT_LANE + k*LANE_SLOTS] = CH_SPACE;
                end
            end
            burst.mask[SLOT_LANE + k*LANE_SLOTS + 1]  = st_lane_reg[k].size == 2'd3;
            burst.mask[SLOT_LANE + k*LANE_SLOTS + 2]  = st_lane_reg[k].size >= 2'd2;
            burst.mask[SLOT_LANE + k*LANE_SLOTS + 3]  = 1'b1;
            burst.chars[SLOT_LANE + k*LANE_SLOTS + 1] = st_lane_reg[k].digit[2];
            burst.chars[SLOT_LANE + k*LANE_SLOTS + 2] = st_lane_reg[k].digit[1];
            burst.chars[SLOT_LANE + k*LANE_SLOTS + 3] = st_lane_reg[k].digit[0];
            ll = ll + size_ext + (LL_W+1)'(1);
        end

        col_inc   = {1'b0, col_reg} + (DIM_W+1)'(1);
        row_inc   = {1'b0, row_reg} + (DIM_W+1)'(1);
        row_end   = col_inc >= {1'b0, width_reg};
        frame_end = row_end && (row_inc >= {1'b0, height_reg});

        burst.mask[SLOT_ROW_END]  = row_end;
        burst.chars[SLOT_ROW_END] = CH_NL;
        burst.frame_end           = frame_end;
    end

    always_comb begin
        width_next    = width_reg;
        height_next   = height_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        ll_next       = ll_reg;
        hdr_sent_next = hdr_sent_reg;
        st_valid_next = st_valid_reg;
        st_lane_next  = st_lane_reg;

        if (cfg_fire && cfg_index == REG_WIDTH) begin
            width_next = cfg_value;
        end
        if (cfg_fire && cfg_index == REG_HEIGHT) begin
            height_next = cfg_value;
        end

        if (load) begin
            st_valid_next = 1'b0;
            hdr_sent_next = !frame_end;
            if (row_end) begin
                ll_next  = '0;
                col_next = '0;
                row_next = frame_end ? '0 : row_inc[DIM_W-1:0];
            end else begin
                ll_next  = ll[LL_W-1:0];
                col_next = col_inc[DIM_W-1:0];
            end
        end

        if (s_valid && s_ready) begin
            st_valid_next = 1'b1;
            st_lane_next  = lane_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= DIM_W'(1);
            height_reg   <= DIM_W'(1);
            col_reg      <= '0;
            row_reg      <= '0;
            ll_reg       <= '0;
            hdr_sent_reg <= 1'b0;
            st_valid_reg <= 1'b0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            ll_reg       <= ll_next;
            hdr_sent_reg <= hdr_sent_next;
            st_valid_reg <= st_valid_next;
        end
        st_lane_reg <= st_lane_next;
    end

    pte_serializer u_serializer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .burst      (burst),
        .load_ready (ser_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
